// ===== design/wlm_pkg.sv =====
// ============================================================================
// wlm_pkg
// Shared constants, types and codes for the water level monitor.
// ============================================================================
`default_nettype none

package wlm_pkg;

    // Window and sample geometry
    localparam int WINDOW_DEPTH = 20;
    localparam int SAMPLE_BITS  = 10;
    localparam int SLOT_BITS    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SUM_BITS     = $clog2(WINDOW_DEPTH * ((2 ** SAMPLE_BITS) - 1) + 1);

    // Floor divide of the sum by the window depth: multiply by a rounded-up
    // reciprocal, exact for every sum below 2**SUM_BITS.
    localparam int AVG_SHIFT     = SUM_BITS + 7;
    localparam int AVG_REC_BITS  = AVG_SHIFT + 1;
    localparam longint AVG_REC   = ((64'd1 << AVG_SHIFT) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
    localparam int AVG_PROD_BITS = SUM_BITS + AVG_REC_BITS;
    localparam int AVG_W         = (SAMPLE_BITS > 10) ? SAMPLE_BITS : 10;

    // Field widths
    localparam int SENS_BITS  = 7;
    localparam int READ_BITS  = 10;
    localparam int TANK_BITS  = 10;
    localparam int FV_BITS    = 10;
    localparam int PCT_BITS   = 8;
    localparam int MM_BITS    = 12;
    localparam int CLASS_BITS = 2;

    // Percentage mapping
    localparam int PCT_FULL   = 100;
    localparam int SCALE_BITS = AVG_W + 7;
    localparam int CMP_BITS   = (SCALE_BITS > READ_BITS + PCT_BITS) ?
                                SCALE_BITS : READ_BITS + PCT_BITS;
    localparam int DIV_CNT_BITS = $clog2(PCT_BITS);
    localparam logic [PCT_BITS-1:0] PCT_SAT = '1;

    // Depth in mm: (pct * height) / 100 via reciprocal
    localparam int MMP_BITS    = PCT_BITS + TANK_BITS;
    localparam int MM_SHIFT    = MMP_BITS + 7;
    localparam int MM_REC_BITS = MM_SHIFT - 6;
    localparam longint MM_REC  = ((64'd1 << MM_SHIFT) + PCT_FULL - 1) / PCT_FULL;
    localparam int MMR_BITS    = MMP_BITS + MM_REC_BITS;

    // Class bands
    localparam int HIGH_FLOOR = 99;
    localparam int MID_LOW    = 30;
    localparam int MID_HIGH   = 80;
    localparam int LOW_BASE   = 30;

    localparam logic [CLASS_BITS-1:0] CLASS_NONE = 2'd0;
    localparam logic [CLASS_BITS-1:0] CLASS_LOW  = 2'd1;
    localparam logic [CLASS_BITS-1:0] CLASS_MID  = 2'd2;
    localparam logic [CLASS_BITS-1:0] CLASS_HIGH = 2'd3;

    // Register map
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;
    localparam logic [1:0] REG_SENSITIVITY = 2'd0;
    localparam logic [1:0] REG_EMPTY       = 2'd1;
    localparam logic [1:0] REG_FULL        = 2'd2;
    localparam logic [1:0] REG_TANK        = 2'd3;

    localparam logic [SENS_BITS-1:0] SENS_RESET  = 7'd10;
    localparam logic [READ_BITS-1:0] EMPTY_RESET = 10'd0;
    localparam logic [READ_BITS-1:0] FULL_RESET  = 10'd610;
    localparam logic [TANK_BITS-1:0] TANK_RESET  = 10'd100;

    typedef struct packed {
        logic [SENS_BITS-1:0] sensitivity;
        logic [READ_BITS-1:0] empty_reading;
        logic [READ_BITS-1:0] full_reading;
        logic [TANK_BITS-1:0] tank_height_mm;
    } cfg_t;

    typedef struct packed {
        logic load_sample;
        logic avg_mul;
        logic avg_take;
        logic scale;
        logic sat_check;
        logic div_step;
        logic mm_mul;
        logic mm_rec;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic bypass;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/water_level_monitor.sv =====
// ============================================================================
// water_level_monitor
// Moving-average water level detector with percent, depth and level class.
// ============================================================================
//   Channel   Dir   Handshake          Payload
//   s_        in    s_valid/s_ready    s_sample
//   m_        out   m_valid/m_ready    filtered_value, fill_percent, level_mm,
//                                      level_class, buzzer_on
//   APB       in    psel/penable       sensitivity, empty, full, tank height
//
// A request is accepted only in the idle state, so the next one waits until
// this one has loaded the output register; the 8-step restoring divider is
// skipped when the percentage is zero or saturates.
// A result stays in the output register while the next request is taken; that
// request then waits in its last step, s_ready low, until the result is taken.
// Synchronous active-low reset; the window clears at once, no sweep.
// ============================================================================
`default_nettype none

module water_level_monitor import wlm_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [SAMPLE_BITS-1:0]   s_sample,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic      [FV_BITS-1:0]       m_filtered_value,
    output logic      [PCT_BITS-1:0]      m_fill_percent,
    output logic      [MM_BITS-1:0]       m_level_mm,
    output logic      [CLASS_BITS-1:0]    m_level_class,
    output logic                          m_buzzer_on,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready
);

    cfg_t      cfg;
    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    assign pready = 1'b1;

    wlm_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    wlm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    wlm_datapath u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .cfg              (cfg),
        .s_sample         (s_sample),
        .m_filtered_value (m_filtered_value),
        .m_fill_percent   (m_fill_percent),
        .m_level_mm       (m_level_mm),
        .m_level_class    (m_level_class)
    );

    assign m_buzzer_on = (m_level_class == CLASS_HIGH);

endmodule

`default_nettype wire

// ===== design/wlm_regs.sv =====
// ============================================================================
// wlm_regs
// APB-style configuration registers of the water level monitor.
// ============================================================================
`default_nettype none

module wlm_regs import wlm_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output cfg_t                          cfg
);

    cfg_t       cfg_reg, cfg_next;
    logic [1:0] index;
    logic       wr_en;

    assign index = paddr[3:2];
    assign wr_en = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (index)
                REG_SENSITIVITY: cfg_next.sensitivity    = pwdata[SENS_BITS-1:0];
                REG_EMPTY:       cfg_next.empty_reading  = pwdata[READ_BITS-1:0];
                REG_FULL:        cfg_next.full_reading   = pwdata[READ_BITS-1:0];
                REG_TANK:        cfg_next.tank_height_mm = pwdata[TANK_BITS-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sensitivity    <= SENS_RESET;
            cfg_reg.empty_reading  <= EMPTY_RESET;
            cfg_reg.full_reading   <= FULL_RESET;
            cfg_reg.tank_height_mm <= TANK_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (index)
            REG_SENSITIVITY: prdata = APB_DATA_BITS'(cfg_reg.sensitivity);
            REG_EMPTY:       prdata = APB_DATA_BITS'(cfg_reg.empty_reading);
            REG_FULL:        prdata = APB_DATA_BITS'(cfg_reg.full_reading);
            REG_TANK:        prdata = APB_DATA_BITS'(cfg_reg.tank_height_mm);
            default:         prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== design/wlm_ctrl.sv =====
// ============================================================================
// wlm_ctrl
// Sequencer: steps one request through the datapath and owns the handshakes.
// ============================================================================
`default_nettype none

module wlm_ctrl import wlm_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  wire logic     m_ready,
    input  wire dp_stat_t stat,
    output ctrl_cmd_t     cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_AVG_MUL  = 4'd1;
    localparam logic [3:0] ST_AVG_TAKE = 4'd2;
    localparam logic [3:0] ST_SCALE    = 4'd3;
    localparam logic [3:0] ST_SAT      = 4'd4;
    localparam logic [3:0] ST_DIV      = 4'd5;
    localparam logic [3:0] ST_MM_MUL   = 4'd6;
    localparam logic [3:0] ST_MM_REC   = 4'd7;
    localparam logic [3:0] ST_OUT      = 4'd8;

    logic [3:0]              state_reg, state_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                    m_valid_reg, m_valid_next;
    logic                    out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_sample = 1'b1;
                    state_next      = ST_AVG_MUL;
                end
            end
            ST_AVG_MUL: begin
                cmd.avg_mul = 1'b1;
                state_next  = ST_AVG_TAKE;
            end
            ST_AVG_TAKE: begin
                cmd.avg_take = 1'b1;
                state_next   = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_SAT;
            end
            ST_SAT: begin
                cmd.sat_check = 1'b1;
                cnt_next      = '0;
                state_next    = stat.bypass ? ST_MM_MUL : ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_BITS'(PCT_BITS - 1)) begin
                    state_next = ST_MM_MUL;
                end
            end
            ST_MM_MUL: begin
                cmd.mm_mul = 1'b1;
                state_next = ST_MM_REC;
            end
            ST_MM_REC: begin
                cmd.mm_rec = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ===== design/wlm_datapath.sv =====
// ============================================================================
// wlm_datapath
// Boxcar window, running sum, percent mapping divider, depth and class.
// ============================================================================
`default_nettype none

module wlm_datapath import wlm_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire ctrl_cmd_t              cmd,
    output dp_stat_t                    stat,
    input  wire cfg_t                   cfg,
    input  wire logic [SAMPLE_BITS-1:0] s_sample,
    output logic      [FV_BITS-1:0]     m_filtered_value,
    output logic      [PCT_BITS-1:0]    m_fill_percent,
    output logic      [MM_BITS-1:0]     m_level_mm,
    output logic      [CLASS_BITS-1:0]  m_level_class
);

    logic [SAMPLE_BITS-1:0]   win_reg [WINDOW_DEPTH];
    logic [SAMPLE_BITS-1:0]   win_next [WINDOW_DEPTH];
    logic [SLOT_BITS-1:0]     slot_reg, slot_next;
    logic [SUM_BITS-1:0]      sum_reg, sum_next;
    logic [AVG_PROD_BITS-1:0] avg_prod_reg, avg_prod_next;
    logic [AVG_W-1:0]         avg_reg, avg_next;
    logic [CMP_BITS-1:0]      scaled_reg, scaled_next;
    logic                     zero_reg, zero_next;
    logic [READ_BITS-1:0]     rem_reg, rem_next;
    logic [PCT_BITS-1:0]      dq_reg, dq_next;
    logic [MMP_BITS-1:0]      mm_prod_reg, mm_prod_next;
    logic [MMR_BITS-1:0]      mm_rec_reg, mm_rec_next;
    logic [CLASS_BITS-1:0]    held_reg, held_next;
    logic [FV_BITS-1:0]       fv_reg, fv_next;
    logic [PCT_BITS-1:0]      pct_reg, pct_next;
    logic [MM_BITS-1:0]       mm_reg, mm_next;

    logic [AVG_W-1:0]         avg_diff;
    logic [READ_BITS-1:0]     span;
    logic [CMP_BITS-1:0]      sat_lim;
    logic                     is_sat;
    logic [READ_BITS:0]       trial;
    logic [READ_BITS:0]       trial_sub;
    logic                     trial_ge;
    logic [PCT_BITS:0]        pct_ext;
    logic                     band_high, band_mid, band_low;
    logic [CLASS_BITS-1:0]    class_new;

    assign avg_diff  = avg_reg - AVG_W'(cfg.empty_reading);
    assign span      = cfg.full_reading - cfg.empty_reading;
    assign sat_lim   = CMP_BITS'({span, {PCT_BITS{1'b0}}});
    assign is_sat    = scaled_reg >= sat_lim;
    assign stat.bypass = zero_reg || is_sat;

    assign trial     = {rem_reg, dq_reg[PCT_BITS-1]};
    assign trial_sub = trial - {1'b0, span};
    assign trial_ge  = trial >= {1'b0, span};

    // Bands tested on p + sensitivity so a large sensitivity never goes negative
    assign pct_ext   = {1'b0, dq_reg};
    assign band_high = (pct_ext + (PCT_BITS+1)'(cfg.sensitivity) >= (PCT_BITS+1)'(HIGH_FLOOR))
                       && (dq_reg < PCT_BITS'(PCT_FULL));
    assign band_mid  = (dq_reg >= PCT_BITS'(MID_LOW)) && (dq_reg < PCT_BITS'(MID_HIGH));
    assign band_low  = pct_ext < ((PCT_BITS+1)'(LOW_BASE) + (PCT_BITS+1)'(cfg.sensitivity));

    always_comb begin
        priority if (band_high) begin
            class_new = CLASS_HIGH;
        end else if (band_mid) begin
            class_new = CLASS_MID;
        end else if (band_low) begin
            class_new = CLASS_LOW;
        end else begin
            class_new = held_reg;
        end
    end

    always_comb begin
        win_next      = win_reg;
        slot_next     = slot_reg;
        sum_next      = sum_reg;
        avg_prod_next = avg_prod_reg;
        avg_next      = avg_reg;
        scaled_next   = scaled_reg;
        zero_next     = zero_reg;
        rem_next      = rem_reg;
        dq_next       = dq_reg;
        mm_prod_next  = mm_prod_reg;
        mm_rec_next   = mm_rec_reg;
        held_next     = held_reg;
        fv_next       = fv_reg;
        pct_next      = pct_reg;
        mm_next       = mm_reg;

        if (cmd.load_sample) begin
            sum_next = sum_reg - SUM_BITS'(win_reg[slot_reg]) + SUM_BITS'(s_sample);
            win_next[slot_reg] = s_sample;
            if (slot_reg == SLOT_BITS'(WINDOW_DEPTH - 1)) begin
                slot_next = '0;
            end else begin
                slot_next = slot_reg + 1'b1;
            end
        end
        if (cmd.avg_mul) begin
            avg_prod_next = AVG_PROD_BITS'(sum_reg) * AVG_PROD_BITS'(AVG_REC);
        end
        if (cmd.avg_take) begin
            avg_next = AVG_W'(avg_prod_reg[AVG_SHIFT +: SAMPLE_BITS]);
        end
        if (cmd.scale) begin
            zero_next   = (cfg.full_reading <= cfg.empty_reading) ||
                          (avg_reg <= AVG_W'(cfg.empty_reading));
            scaled_next = CMP_BITS'(avg_diff) * CMP_BITS'(PCT_FULL);
        end
        if (cmd.sat_check) begin
            priority if (zero_reg) begin
                dq_next = '0;
            end else if (is_sat) begin
                dq_next = PCT_SAT;
            end else begin
                rem_next = scaled_reg[PCT_BITS +: READ_BITS];
                dq_next  = scaled_reg[PCT_BITS-1:0];
            end
        end
        if (cmd.div_step) begin
            rem_next = trial_ge ? trial_sub[READ_BITS-1:0] : trial[READ_BITS-1:0];
            dq_next  = {dq_reg[PCT_BITS-2:0], trial_ge};
        end
        if (cmd.mm_mul) begin
            mm_prod_next = MMP_BITS'(dq_reg) * MMP_BITS'(cfg.tank_height_mm);
        end
        if (cmd.mm_rec) begin
            mm_rec_next = MMR_BITS'(mm_prod_reg) * MMR_BITS'(MM_REC);
        end
        if (cmd.out_load) begin
            held_next = class_new;
            fv_next   = avg_reg[FV_BITS-1:0];
            pct_next  = dq_reg;
            mm_next   = mm_rec_reg[MM_SHIFT +: MM_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                win_reg[i] <= '0;
            end
            slot_reg <= '0;
            sum_reg  <= '0;
            held_reg <= CLASS_NONE;
        end else begin
            win_reg  <= win_next;
            slot_reg <= slot_next;
            sum_reg  <= sum_next;
            held_reg <= held_next;
        end
    end

    always_ff @(posedge aclk) begin
        avg_prod_reg <= avg_prod_next;
        avg_reg      <= avg_next;
        scaled_reg   <= scaled_next;
        zero_reg     <= zero_next;
        rem_reg      <= rem_next;
        dq_reg       <= dq_next;
        mm_prod_reg  <= mm_prod_next;
        mm_rec_reg   <= mm_rec_next;
        fv_reg       <= fv_next;
        pct_reg      <= pct_next;
        mm_reg       <= mm_next;
    end

    assign m_filtered_value = fv_reg;
    assign m_fill_percent   = pct_reg;
    assign m_level_mm       = mm_reg;
    assign m_level_class    = held_reg;

endmodule

`default_nettype wire

// ===== design/wlm_checker.sv =====
// ============================================================================
// wlm_checker
// Port-level checks on the water level monitor, bound to the top level.
// ============================================================================
`default_nettype none

module wlm_checker import wlm_pkg::*; (
    input wire logic                     aclk,
    input wire logic                     aresetn,
    input wire logic                     s_valid,
    input wire logic                     s_ready,
    input wire logic [SAMPLE_BITS-1:0]   s_sample,
    input wire logic                     m_valid,
    input wire logic                     m_ready,
    input wire logic [FV_BITS-1:0]       m_filtered_value,
    input wire logic [PCT_BITS-1:0]      m_fill_percent,
    input wire logic [MM_BITS-1:0]       m_level_mm,
    input wire logic [CLASS_BITS-1:0]    m_level_class,
    input wire logic                     m_buzzer_on,
    input wire logic                     psel,
    input wire logic                     penable,
    input wire logic                     pwrite,
    input wire logic [APB_ADDR_BITS-1:0] paddr,
    input wire logic [APB_DATA_BITS-1:0] pwdata,
    input wire logic [APB_DATA_BITS-1:0] prdata,
    input wire logic                     pready
);

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("s_ready still high after a request was taken");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_filtered_value) &&
        $stable(m_fill_percent) && $stable(m_level_mm) && $stable(m_level_class))
        else $error("stalled result changed");

    a_buzzer_tracks_class: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_buzzer_on == (m_level_class == CLASS_HIGH)))
        else $error("buzzer disagrees with level class");

    a_empty_zero_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_fill_percent == '0) |-> (m_level_mm == '0))
        else $error("nonzero depth at zero percent");

    a_high_below_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_level_class == CLASS_HIGH) && (m_fill_percent != '0) |->
        (m_fill_percent < PCT_BITS'(PCT_FULL)) || $past(m_level_class) == CLASS_HIGH)
        else $error("high class entered at or above full");

endmodule

bind water_level_monitor wlm_checker u_chk (.*);

`default_nettype wire
